FILE: sv/smsel_pkg.sv
// Shared types, register indexes and mode codes of the spacecraft mode selector.
package smsel_pkg;

  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW = 56;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [2:0] {
    MODE_NOMINAL = 3'd0,
    MODE_COMM    = 3'd1,
    MODE_UPDATE  = 3'd2,
    MODE_SAFE    = 3'd3,
    MODE_ULP     = 3'd4,
    MODE_DECOM   = 3'd5
  } mode_t;

  localparam logic [CfgIdxW-1:0] REG_VOLT_HIGH = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_VOLT_LOW  = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_CURR_HIGH = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_CURR_LOW  = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_TEMP_HIGH = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_TEMP_LOW  = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_BATT_SAFE = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_BATT_CRIT = 4'd7;

  localparam logic [6:0] UPDATE_BATTERY_MIN = 7'd70;

  typedef struct packed {
    logic        [15:0] volt_high;
    logic        [15:0] volt_low;
    logic signed [15:0] curr_high;
    logic signed [15:0] curr_low;
    logic signed [12:0] temp_high;
    logic signed [12:0] temp_low;
    logic        [6:0]  batt_safe;
    logic        [6:0]  batt_crit;
  } limits_t;

  typedef struct packed {
    logic        life_expired;
    logic        update_request;
    logic        comm_window;
    logic [6:0]  battery_percent;
    logic signed [12:0] board_temp;
    logic signed [15:0] bus_current;
    logic [15:0] bus_voltage;
  } sample_t;

endpackage

FILE: sv/smsel_cfg.sv
// Configuration register file holding the health windows and battery levels.
module smsel_cfg
  import smsel_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output limits_t             limits
);

  limits_t limits_r;
  limits_t limits_nxt;

  assign cfg_ready = 1'b1;
  assign limits = limits_r;

  always_comb begin
    limits_nxt = limits_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_VOLT_HIGH: limits_nxt.volt_high = cfg_data;
        REG_VOLT_LOW:  limits_nxt.volt_low  = cfg_data;
        REG_CURR_HIGH: limits_nxt.curr_high = cfg_data;
        REG_CURR_LOW:  limits_nxt.curr_low  = cfg_data;
        REG_TEMP_HIGH: limits_nxt.temp_high = cfg_data[12:0];
        REG_TEMP_LOW:  limits_nxt.temp_low  = cfg_data[12:0];
        REG_BATT_SAFE: limits_nxt.batt_safe = cfg_data[6:0];
        REG_BATT_CRIT: limits_nxt.batt_crit = cfg_data[6:0];
        default:       limits_nxt = limits_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.volt_high <= 16'd8400;
      limits_r.volt_low  <= 16'd6000;
      limits_r.curr_high <= 16'sd3000;
      limits_r.curr_low  <= -16'sd3000;
      limits_r.temp_high <= 13'sd850;
      limits_r.temp_low  <= -13'sd400;
      limits_r.batt_safe <= 7'd20;
      limits_r.batt_crit <= 7'd10;
    end else begin
      limits_r <= limits_nxt;
    end
  end

endmodule

FILE: sv/smsel_core.sv
// Health check and next-mode decision for one sample beat.
module smsel_core
  import smsel_pkg::*;
(
  input  sample_t sample,
  input  limits_t limits,
  input  mode_t   mode,
  output mode_t   next_mode,
  output logic    healthy
);

  logic volt_ok;
  logic curr_ok;
  logic temp_ok;
  logic batt_ok;
  logic crit;
  logic upd_ok;

  assign volt_ok = (sample.bus_voltage <= limits.volt_high) &&
                   (sample.bus_voltage >= limits.volt_low);
  assign curr_ok = (sample.bus_current <= limits.curr_high) &&
                   (sample.bus_current >= limits.curr_low);
  assign temp_ok = (sample.board_temp <= limits.temp_high) &&
                   (sample.board_temp >= limits.temp_low);
  assign batt_ok = sample.battery_percent >= limits.batt_safe;
  assign healthy = volt_ok && curr_ok && temp_ok && batt_ok;

  assign crit   = sample.battery_percent < limits.batt_crit;
  assign upd_ok = sample.update_request && (sample.battery_percent > UPDATE_BATTERY_MIN);

  always_comb begin
    unique case (mode)
      MODE_NOMINAL: begin
        if (!healthy) next_mode = MODE_SAFE;
        else if (sample.comm_window) next_mode = MODE_COMM;
        else next_mode = MODE_NOMINAL;
      end
      MODE_COMM: begin
        if (!healthy) next_mode = MODE_SAFE;
        else if (!sample.comm_window) next_mode = MODE_NOMINAL;
        else if (upd_ok) next_mode = MODE_UPDATE;
        else next_mode = MODE_COMM;
      end
      MODE_UPDATE: begin
        next_mode = sample.update_request ? MODE_UPDATE : MODE_COMM;
      end
      MODE_SAFE: begin
        if (crit) next_mode = MODE_ULP;
        else if (upd_ok) next_mode = MODE_UPDATE;
        else if (healthy) next_mode = MODE_NOMINAL;
        else next_mode = MODE_SAFE;
      end
      MODE_ULP: begin
        if (!crit) next_mode = MODE_SAFE;
        else if (sample.life_expired) next_mode = MODE_DECOM;
        else next_mode = MODE_ULP;
      end
      MODE_DECOM: begin
        next_mode = MODE_DECOM;
      end
      default: begin
        next_mode = MODE_NOMINAL;
      end
    endcase
  end

endmodule

FILE: sv/spacecraft_mode_selector.sv
// Top level of the spacecraft mode selector: stream ports, mode register and result register.
//
// Each input beat is one evaluation tick and yields exactly one result beat with the new
// mode and the health flag. The health windows and the mode decision are evaluated in the
// cycle the beat is accepted and are captured in the result register at the accepting edge,
// so the result beat is offered from the next cycle on; a new beat is taken every clock as long as
// the result register is empty or being drained, so the block sustains one tick per cycle.
// Configuration writes are taken in every cycle.
module spacecraft_mode_selector
  import smsel_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // Fields from bit 0: bus_voltage[15:0], bus_current[31:16], board_temp[44:32],
  // battery_percent[51:45], comm_window[52], update_request[53], life_expired[54].
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // Fields from bit 0: next_mode[2:0], healthy[3].
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  limits_t limits;
  sample_t sample;
  mode_t   mode_r;
  mode_t   mode_nxt;
  logic    healthy;
  logic    in_beat;
  logic    out_tvalid_r;
  logic    out_tvalid_nxt;
  logic [OutDataW-1:0] out_tdata_r;

  assign sample    = sample_t'(in_tdata[InDataW-2:0]);
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  smsel_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  smsel_core u_core (
    .sample    (sample),
    .limits    (limits),
    .mode      (mode_r),
    .next_mode (mode_nxt),
    .healthy   (healthy)
  );

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (in_beat) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_NOMINAL;
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      if (in_beat) begin
        mode_r <= mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_tdata_r <= {{(OutDataW-4){1'b0}}, healthy, mode_nxt};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench of the spacecraft mode selector with a mode and health predictor.
module testbench;
  import smsel_pkg::*;

  localparam int CycleLimit = 200000;

  typedef struct {
    mode_t mode;
    logic  healthy;
  } mode_result_t;

  class mode_scoreboard;
    limits_t      lim;
    mode_t        mode_now;
    mode_result_t expected_results[$];
    int           failures;
    int           reported;
    int           checked;

    function new();
      lim = '{volt_high: 16'd8400, volt_low: 16'd6000, curr_high: 16'sd3000,
              curr_low: -16'sd3000, temp_high: 13'sd850, temp_low: -13'sd400,
              batt_safe: 7'd20, batt_crit: 7'd10};
      mode_now = MODE_NOMINAL;
      failures = 0;
      reported = 0;
      checked = 0;
    endfunction

    function void write_limit(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_VOLT_HIGH: lim.volt_high = val;
        REG_VOLT_LOW:  lim.volt_low = val;
        REG_CURR_HIGH: lim.curr_high = val;
        REG_CURR_LOW:  lim.curr_low = val;
        REG_TEMP_HIGH: lim.temp_high = val[12:0];
        REG_TEMP_LOW:  lim.temp_low = val[12:0];
        REG_BATT_SAFE: lim.batt_safe = val[6:0];
        REG_BATT_CRIT: lim.batt_crit = val[6:0];
        default: ;
      endcase
    endfunction

    function void note_sample(sample_t s);
      logic         ok;
      logic         crit;
      logic         upd_ok;
      mode_t        nm;
      mode_result_t r;
      ok = 1'b1;
      if (s.bus_voltage > lim.volt_high || s.bus_voltage < lim.volt_low) ok = 1'b0;
      if ($signed(s.bus_current) > $signed(lim.curr_high) ||
          $signed(s.bus_current) < $signed(lim.curr_low)) ok = 1'b0;
      if ($signed(s.board_temp) > $signed(lim.temp_high) ||
          $signed(s.board_temp) < $signed(lim.temp_low)) ok = 1'b0;
      if (s.battery_percent < lim.batt_safe) ok = 1'b0;
      crit = s.battery_percent < lim.batt_crit;
      upd_ok = s.update_request && (s.battery_percent > UPDATE_BATTERY_MIN);
      nm = MODE_NOMINAL;
      case (mode_now)
        MODE_NOMINAL: begin
          if (!ok) nm = MODE_SAFE;
          else if (s.comm_window) nm = MODE_COMM;
          else nm = MODE_NOMINAL;
        end
        MODE_COMM: begin
          if (!ok) nm = MODE_SAFE;
          else if (!s.comm_window) nm = MODE_NOMINAL;
          else if (upd_ok) nm = MODE_UPDATE;
          else nm = MODE_COMM;
        end
        MODE_UPDATE: begin
          if (s.update_request) nm = MODE_UPDATE;
          else nm = MODE_COMM;
        end
        MODE_SAFE: begin
          if (crit) nm = MODE_ULP;
          else if (upd_ok) nm = MODE_UPDATE;
          else if (ok) nm = MODE_NOMINAL;
          else nm = MODE_SAFE;
        end
        MODE_ULP: begin
          if (!crit) nm = MODE_SAFE;
          else if (s.life_expired) nm = MODE_DECOM;
          else nm = MODE_ULP;
        end
        MODE_DECOM: nm = MODE_DECOM;
        default: nm = MODE_NOMINAL;
      endcase
      mode_now = nm;
      r.mode = nm;
      r.healthy = ok;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [OutDataW-1:0] d);
      mode_result_t r;
      checked++;
      if (expected_results.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result beat %0d: mode %0d healthy %0b", checked, d[2:0], d[3]);
        end
        return;
      end
      r = expected_results.pop_front();
      if (d[2:0] !== r.mode || d[3] !== r.healthy) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("result beat %0d: expected mode %0d healthy %0b, got mode %0d healthy %0b",
                   checked, r.mode, r.healthy, d[2:0], d[3]);
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  mode_scoreboard sb;
  bit             calm = 1'b0;
  int             cycles = 0;

  spacecraft_mode_selector uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** spacecraft_mode_selector: FAILED **");
      $finish;
    end
  end

  function automatic sample_t mk(int v, int c, int t, int b, bit cw, bit ur, bit mt);
    sample_t s;
    s.bus_voltage = 16'(v);
    s.bus_current = 16'(c);
    s.board_temp = 13'(t);
    s.battery_percent = 7'(b);
    s.comm_window = cw;
    s.update_request = ur;
    s.life_expired = mt;
    return s;
  endfunction

  function automatic int pick_between(int lo, int hi);
    if (lo > hi) return lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Mostly values inside the current windows, with edges and raw bit patterns mixed in.
  function automatic int pick_field(int lo, int hi, int mask);
    case ($urandom_range(9))
      6: begin
        case ($urandom_range(3))
          0: return lo - 1;
          1: return lo;
          2: return hi;
          default: return hi + 1;
        endcase
      end
      7, 8, 9: return int'($urandom) & mask;
      default: return pick_between(lo, hi);
    endcase
  endfunction

  function automatic sample_t make_sample(bit allow_decom);
    int v, c, t, b;
    bit mt;
    v = pick_field(int'(sb.lim.volt_low), int'(sb.lim.volt_high), 32'hFFFF);
    c = pick_field(int'($signed(sb.lim.curr_low)), int'($signed(sb.lim.curr_high)), 32'hFFFF);
    t = pick_field(int'($signed(sb.lim.temp_low)), int'($signed(sb.lim.temp_high)), 32'h1FFF);
    case ($urandom_range(9))
      0, 1: b = $urandom_range(127);
      2: b = int'(sb.lim.batt_safe) - 1 + int'($urandom_range(2));
      3: b = int'(sb.lim.batt_crit) - 1 + int'($urandom_range(2));
      4: b = int'(UPDATE_BATTERY_MIN) + int'($urandom_range(1));
      default: b = $urandom_range(100);
    endcase
    b = b & 32'h7F;
    mt = ($urandom_range(4) == 0);
    if (!allow_decom && sb.mode_now == MODE_ULP && b < int'(sb.lim.batt_crit)) mt = 1'b0;
    return mk(v, c, t, b, 1'($urandom_range(1)), 1'($urandom_range(1)), mt);
  endfunction

  task automatic send_sample(sample_t s);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, s};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s);
  endtask

  task automatic run_random(int count, bit allow_decom);
    repeat (count) send_sample(make_sample(allow_decom));
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Bits above a register's width carry random noise that the block must drop.
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, int v);
    logic [CfgDataW-1:0] val;
    val = 16'(v);
    case (idx)
      REG_TEMP_HIGH, REG_TEMP_LOW: val = (16'($urandom) & 16'hE000) | (val & 16'h1FFF);
      REG_BATT_SAFE, REG_BATT_CRIT: val = (16'($urandom) & 16'hFF80) | (val & 16'h007F);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_limit(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic cfg_all(int vh, int vl, int ch, int cl, int th, int tl, int bs, int bc);
    cfg_write(REG_VOLT_HIGH, vh);
    cfg_write(REG_VOLT_LOW, vl);
    cfg_write(REG_CURR_HIGH, ch);
    cfg_write(REG_CURR_LOW, cl);
    cfg_write(REG_TEMP_HIGH, th);
    cfg_write(REG_TEMP_LOW, tl);
    cfg_write(REG_BATT_SAFE, bs);
    cfg_write(REG_BATT_CRIT, bc);
  endtask

  task automatic run_directed();
    send_sample(mk(0, 0, 0, 0, 0, 0, 0));
    send_sample(mk(65535, 32767, 4095, 127, 1, 1, 1));
    send_sample(mk(6000, -3000, -400, 20, 1, 1, 0));
    send_sample(mk(8400, 3000, 850, 71, 1, 0, 0));
    send_sample(mk(8400, 3000, 850, 70, 1, 1, 0));
    send_sample(mk(7000, 0, 0, 71, 1, 1, 0));
    send_sample(mk(7000, 0, 0, 71, 0, 0, 0));
    send_sample(mk(7000, 0, 0, 50, 0, 0, 0));
    send_sample(mk(7000, 0, 0, 50, 0, 0, 0));
    send_sample(mk(7000, 0, 0, 50, 1, 0, 0));
    send_sample(mk(8401, 0, 0, 50, 1, 0, 0));
    send_sample(mk(5999, 0, 0, 50, 0, 0, 1));
    send_sample(mk(7000, 3001, 0, 50, 1, 1, 0));
    send_sample(mk(7000, -3001, 0, 50, 0, 0, 0));
    send_sample(mk(7000, 0, 851, 50, 0, 0, 0));
    send_sample(mk(7000, 0, -401, 50, 0, 0, 0));
    send_sample(mk(7000, 0, 0, 19, 0, 0, 0));
    send_sample(mk(7000, 0, 0, 20, 0, 0, 0));
    send_sample(mk(7000, 0, 0, 9, 0, 0, 0));
    send_sample(mk(7000, 0, 0, 9, 0, 0, 0));
    send_sample(mk(7000, 0, 0, 9, 0, 0, 0));
    send_sample(mk(7000, -32768, -4096, 10, 0, 0, 1));
    send_sample(mk(7000, 0, 0, 101, 0, 1, 0));
    send_sample(mk(7000, 0, 0, 50, 0, 0, 0));
  endtask

  initial begin
    int lo;
    sb = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain();

    lo = $urandom_range(3000, 7000);
    cfg_all(lo + int'($urandom_range(500, 3000)), lo, $urandom_range(500, 5000),
            -int'($urandom_range(500, 5000)), $urandom_range(200, 1200),
            -int'($urandom_range(0, 800)), $urandom_range(5, 40), $urandom_range(2, 25));
    cfg_write(4'(REG_BATT_CRIT + 1 + $urandom_range(7)), $urandom);
    run_random(150, 1'b0);
    drain();

    cfg_all(65535, 0, 32767, -32768, 4095, -4096, 0, 0);
    run_random(80, 1'b0);
    drain();

    cfg_all(0, 65535, -32768, 32767, -4096, 4095, 127, 100);
    cfg_write(4'(REG_BATT_CRIT + 1 + $urandom_range(7)), $urandom);
    run_random(80, 1'b0);
    drain();

    cfg_all(8400, 6000, 3000, -3000, 850, -400, 20, 10);
    calm = 1'b1;
    run_random(150, 1'b0);
    drain();
    calm = 1'b0;

    cfg_all(8400, 6000, 3000, -3000, 850, -400, $urandom_range(30, 40),
            $urandom_range(40, 60));
    run_random(150, 1'b0);
    repeat (5) send_sample(mk(7000, 0, 0, 0, 0, 0, 1));
    run_random(40, 1'b1);
    drain();

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("** spacecraft_mode_selector: PASSED **");
    end else begin
      $display("** spacecraft_mode_selector: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/smsel_pkg.sv
sv/smsel_cfg.sv
sv/smsel_core.sv
sv/spacecraft_mode_selector.sv
sim/testbench.sv
